FILE: sv/nfa_pkg.sv
// Package for the next-fit code allocator: payload structs, field widths, status codes,
// controller states, datapath operations and the status struct between them.
// Used by every module of the block except nfa_ram; depends on nothing.
package nfa_pkg;

  localparam int unsigned CODE_W   = 16;
  localparam int unsigned GRANT_W  = 13;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned WORD_W   = 64;
  localparam int unsigned IDX_W    = 6;

  localparam int unsigned CODE_BASE     = 1000;
  localparam int unsigned CAPACITY_DEF  = 4096;
  localparam int unsigned GROW_STEP_DEF = 256;

  localparam logic MODE_ALLOC   = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  localparam logic [STATUS_W-1:0] STAT_GRANTED  = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_RELEASED = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_IGNORED  = 2'd3;

  typedef struct packed {
    logic              mode;
    logic [CODE_W-1:0] release_code;
  } nfa_in_t;

  typedef struct packed {
    logic [GRANT_W-1:0]  granted_code;
    logic [STATUS_W-1:0] status;
  } nfa_out_t;

  typedef enum logic [2:0] {
    CS_CLEAR,
    CS_IDLE,
    CS_READ,
    CS_DECIDE,
    CS_SCAN,
    CS_GROW,
    CS_DONE
  } ctrl_state_e;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_CLEAR,
    DP_CAPTURE,
    DP_READ,
    DP_REL_WRITE,
    DP_IGNORE,
    DP_PTR_TAKE,
    DP_SCAN_START,
    DP_SCAN_STEP,
    DP_SCAN_TAKE,
    DP_GROW_READ,
    DP_GROW_TAKE,
    DP_FULL,
    DP_OUT_LOAD
  } dp_op_e;

  typedef struct packed {
    logic clr_last;
    logic is_release;
    logic rel_in_range;
    logic ptr_free;
    logic lim_zero;
    logic scan_found;
    logic scan_exhausted;
    logic can_grow;
  } dp_stat_t;

endpackage

FILE: sv/nfa_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package needed.
module nfa_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/nfa_datapath.sv
// Datapath of the next-fit code allocator: bitmap RAM, pointer and window registers,
// word scan counters, result and output registers. Depends on nfa_pkg and nfa_ram.
module nfa_datapath import nfa_pkg::*; #(
  parameter int unsigned CAPACITY  = CAPACITY_DEF,
  parameter int unsigned GROW_STEP = GROW_STEP_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  dp_op_e   op_i,
  input  nfa_in_t  in_data_i,
  output dp_stat_t stat_o,
  output nfa_out_t out_data_o
);

  localparam int unsigned WORD_COUNT = (CAPACITY + WORD_W - 1) / WORD_W;
  localparam int unsigned WA_W       = $clog2(WORD_COUNT);
  localparam int unsigned LIM_W      = $clog2(WORD_COUNT + 1);
  localparam int unsigned SLOT_W     = $clog2(CAPACITY + 1);
  localparam int unsigned GW         = $clog2(CAPACITY + GROW_STEP + 1);
  localparam int unsigned OFF_W      = CODE_W + 1;
  localparam int unsigned SUM_W      = ((SLOT_W > GRANT_W) ? SLOT_W : GRANT_W) + 1;

  logic                mode_q, mode_d;
  logic [CODE_W-1:0]   code_q, code_d;
  logic [SLOT_W-1:0]   ns_q, ns_d;
  logic [SLOT_W-1:0]   win_q, win_d;
  logic [SLOT_W-1:0]   slot_q, slot_d;
  logic [WA_W-1:0]     scan_addr_q, scan_addr_d;
  logic [LIM_W-1:0]    scan_left_q, scan_left_d;
  logic                chk_valid_q, chk_valid_d;
  logic [WA_W-1:0]     chk_addr_q, chk_addr_d;
  logic [WA_W-1:0]     clr_addr_q, clr_addr_d;
  logic [GRANT_W-1:0]  res_code_q, res_code_d;
  logic [STATUS_W-1:0] res_status_q, res_status_d;
  nfa_out_t            out_q, out_d;

  logic                ram_we, ram_re;
  logic [WA_W-1:0]     ram_waddr, ram_raddr;
  logic [WORD_W-1:0]   ram_wdata, rd_data;

  logic [OFF_W-1:0]    rel_off;
  logic                rel_in_range;
  logic [SLOT_W-1:0]   rel_slot;
  logic [WA_W-1:0]     rel_word, ns_word, win_word, slot_word;
  logic                ptr_in_win;
  logic [LIM_W-1:0]    lim;
  logic [WA_W-1:0]     scan_start;
  logic [WORD_W-1:0]   lz_onehot;
  logic [IDX_W-1:0]    lz_idx;
  logic [GW-1:0]       grow_sum;
  logic                can_grow;
  logic                take_en;
  logic [SLOT_W-1:0]   take_slot;
  logic [SUM_W-1:0]    code_sum;

  function automatic logic [WORD_W-1:0] bit_mask(input logic [IDX_W-1:0] idx);
    return WORD_W'(1) << idx;
  endfunction

  nfa_ram #(
    .WIDTH(WORD_W),
    .DEPTH(WORD_COUNT)
  ) u_bitmap (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(rd_data)
  );

  assign rel_off      = OFF_W'(code_q) - OFF_W'(CODE_BASE);
  assign rel_in_range = (code_q >= CODE_W'(CODE_BASE)) && (rel_off < OFF_W'(CAPACITY));
  assign rel_slot     = SLOT_W'(rel_off);
  assign rel_word     = rel_slot[IDX_W +: WA_W];
  assign ns_word      = ns_q[IDX_W +: WA_W];
  assign win_word     = win_q[IDX_W +: WA_W];
  assign slot_word    = slot_q[IDX_W +: WA_W];
  assign ptr_in_win   = ns_q < win_q;
  assign lim          = LIM_W'(win_q >> IDX_W);

  // When the pointer is outside the window or in its top partial word, there is
  // nothing above it to scan, so the scan starts from word 0.
  assign scan_start = (ptr_in_win && (LIM_W'(ns_word) != lim)) ? ns_word : '0;

  // Lowest clear bit as a one-hot mask, then encoded.
  assign lz_onehot = ~rd_data & (rd_data + WORD_W'(1));

  always_comb begin
    lz_idx = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (lz_onehot[i]) begin
        lz_idx = lz_idx | IDX_W'(i);
      end
    end
  end

  assign grow_sum = GW'(win_q) + GW'(GROW_STEP);
  assign can_grow = grow_sum <= GW'(CAPACITY);
  assign code_sum = SUM_W'(take_slot) + SUM_W'(CODE_BASE);

  always_comb begin
    mode_d       = mode_q;
    code_d       = code_q;
    ns_d         = ns_q;
    win_d        = win_q;
    slot_d       = slot_q;
    scan_addr_d  = scan_addr_q;
    scan_left_d  = scan_left_q;
    chk_valid_d  = chk_valid_q;
    chk_addr_d   = chk_addr_q;
    clr_addr_d   = clr_addr_q;
    res_code_d   = res_code_q;
    res_status_d = res_status_q;
    out_d        = out_q;
    ram_we       = 1'b0;
    ram_waddr    = clr_addr_q;
    ram_wdata    = '0;
    ram_re       = 1'b0;
    ram_raddr    = ns_word;
    take_en      = 1'b0;
    take_slot    = slot_q;

    case (op_i)
      DP_CLEAR: begin
        ram_we     = 1'b1;
        clr_addr_d = clr_addr_q + WA_W'(1);
      end
      DP_CAPTURE: begin
        mode_d = in_data_i.mode;
        code_d = in_data_i.release_code;
      end
      DP_READ: begin
        ram_re    = 1'b1;
        ram_raddr = (mode_q == MODE_RELEASE) ? rel_word : ns_word;
      end
      DP_REL_WRITE: begin
        ram_we       = 1'b1;
        ram_waddr    = rel_word;
        ram_wdata    = rd_data & ~bit_mask(rel_slot[IDX_W-1:0]);
        res_code_d   = '0;
        res_status_d = STAT_RELEASED;
      end
      DP_IGNORE: begin
        res_code_d   = '0;
        res_status_d = STAT_IGNORED;
      end
      DP_PTR_TAKE: begin
        ram_we    = 1'b1;
        ram_waddr = ns_word;
        ram_wdata = rd_data | bit_mask(ns_q[IDX_W-1:0]);
        take_en   = 1'b1;
        take_slot = ns_q;
      end
      DP_SCAN_START: begin
        scan_addr_d = scan_start;
        scan_left_d = lim;
        chk_valid_d = 1'b0;
      end
      DP_SCAN_STEP: begin
        if (scan_left_q != '0) begin
          ram_re      = 1'b1;
          ram_raddr   = scan_addr_q;
          chk_valid_d = 1'b1;
          chk_addr_d  = scan_addr_q;
          scan_left_d = scan_left_q - LIM_W'(1);
          if ((LIM_W'(scan_addr_q) + LIM_W'(1)) == lim) begin
            scan_addr_d = '0;
          end else begin
            scan_addr_d = scan_addr_q + WA_W'(1);
          end
        end else begin
          chk_valid_d = 1'b0;
        end
      end
      DP_SCAN_TAKE: begin
        ram_we      = 1'b1;
        ram_waddr   = chk_addr_q;
        ram_wdata   = rd_data | lz_onehot;
        chk_valid_d = 1'b0;
        take_en     = 1'b1;
        take_slot   = SLOT_W'({chk_addr_q, lz_idx});
      end
      DP_GROW_READ: begin
        ram_re      = 1'b1;
        ram_raddr   = win_word;
        slot_d      = win_q;
        chk_valid_d = 1'b0;
      end
      DP_GROW_TAKE: begin
        ram_we    = 1'b1;
        ram_waddr = slot_word;
        ram_wdata = rd_data | bit_mask(slot_q[IDX_W-1:0]);
        win_d     = SLOT_W'(grow_sum);
        take_en   = 1'b1;
        take_slot = slot_q;
      end
      DP_FULL: begin
        ns_d         = win_q;
        chk_valid_d  = 1'b0;
        res_code_d   = '0;
        res_status_d = STAT_FULL;
      end
      DP_OUT_LOAD: begin
        out_d.granted_code = res_code_q;
        out_d.status       = res_status_q;
      end
      default: begin
      end
    endcase

    if (take_en) begin
      ns_d         = take_slot + SLOT_W'(1);
      res_code_d   = code_sum[GRANT_W-1:0];
      res_status_d = STAT_GRANTED;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ns_q        <= '0;
      win_q       <= '0;
      clr_addr_q  <= '0;
      scan_left_q <= '0;
      chk_valid_q <= 1'b0;
    end else begin
      ns_q        <= ns_d;
      win_q       <= win_d;
      clr_addr_q  <= clr_addr_d;
      scan_left_q <= scan_left_d;
      chk_valid_q <= chk_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q       <= mode_d;
    code_q       <= code_d;
    slot_q       <= slot_d;
    scan_addr_q  <= scan_addr_d;
    chk_addr_q   <= chk_addr_d;
    res_code_q   <= res_code_d;
    res_status_q <= res_status_d;
    out_q        <= out_d;
  end

  assign stat_o.clr_last       = clr_addr_q == WA_W'(WORD_COUNT - 1);
  assign stat_o.is_release     = mode_q == MODE_RELEASE;
  assign stat_o.rel_in_range   = rel_in_range;
  assign stat_o.ptr_free       = ptr_in_win && !rd_data[ns_q[IDX_W-1:0]];
  assign stat_o.lim_zero       = lim == '0;
  assign stat_o.scan_found     = chk_valid_q && (rd_data != '1);
  assign stat_o.scan_exhausted = !chk_valid_q && (scan_left_q == '0);
  assign stat_o.can_grow       = can_grow;

  assign out_data_o = out_q;

endmodule

FILE: sv/nfa_ctrl.sv
// Controller of the next-fit code allocator: sequences the clearing pass, the lookup,
// the word scan and window growth, and owns the handshakes. Depends on nfa_pkg.
module nfa_ctrl import nfa_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  dp_stat_t stat_i,
  output dp_op_e   op_o
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      CS_CLEAR: begin
        if (stat_i.clr_last) begin
          state_d = CS_IDLE;
        end
      end
      CS_IDLE: begin
        if (in_valid_i) begin
          state_d = CS_READ;
        end
      end
      CS_READ: begin
        state_d = CS_DECIDE;
      end
      CS_DECIDE: begin
        if (stat_i.is_release || stat_i.ptr_free) begin
          state_d = CS_DONE;
        end else if (!stat_i.lim_zero) begin
          state_d = CS_SCAN;
        end else if (stat_i.can_grow) begin
          state_d = CS_GROW;
        end else begin
          state_d = CS_DONE;
        end
      end
      CS_SCAN: begin
        if (stat_i.scan_found) begin
          state_d = CS_DONE;
        end else if (stat_i.scan_exhausted) begin
          state_d = stat_i.can_grow ? CS_GROW : CS_DONE;
        end
      end
      CS_GROW: begin
        state_d = CS_DONE;
      end
      CS_DONE: begin
        if (out_free) begin
          state_d = CS_IDLE;
        end
      end
      default: begin
        state_d = CS_IDLE;
      end
    endcase
  end

  always_comb begin
    op_o        = DP_NOP;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      CS_CLEAR: begin
        op_o = DP_CLEAR;
      end
      CS_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_o = DP_CAPTURE;
        end
      end
      CS_READ: begin
        op_o = DP_READ;
      end
      CS_DECIDE: begin
        if (stat_i.is_release) begin
          op_o = stat_i.rel_in_range ? DP_REL_WRITE : DP_IGNORE;
        end else if (stat_i.ptr_free) begin
          op_o = DP_PTR_TAKE;
        end else if (!stat_i.lim_zero) begin
          op_o = DP_SCAN_START;
        end else if (stat_i.can_grow) begin
          op_o = DP_GROW_READ;
        end else begin
          op_o = DP_FULL;
        end
      end
      CS_SCAN: begin
        if (stat_i.scan_found) begin
          op_o = DP_SCAN_TAKE;
        end else if (stat_i.scan_exhausted) begin
          op_o = stat_i.can_grow ? DP_GROW_READ : DP_FULL;
        end else begin
          op_o = DP_SCAN_STEP;
        end
      end
      CS_GROW: begin
        op_o = DP_GROW_TAKE;
      end
      CS_DONE: begin
        if (out_free) begin
          op_o        = DP_OUT_LOAD;
          out_valid_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CS_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: sv/next_fit_id_allocator.sv
// Sequence: after the input transfer a request passes the read and decide states; a release
// or an allocate whose pointer slot is free then goes to the done state, a grow on an empty
// window passes the grow state first, and a scan reads the window's words one by one before
// it takes a slot, ends in the store-full status or grows. out_valid_o rises when done loads.
// The block works on one item at a time; the next input transfer can come in the cycle
// after the result is loaded. Reset clears pointer, window and handshakes at once, then
// zeroes the CAPACITY/64 bitmap words.
module next_fit_id_allocator import nfa_pkg::*; #(
  parameter int unsigned CAPACITY  = CAPACITY_DEF,
  parameter int unsigned GROW_STEP = GROW_STEP_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  nfa_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output nfa_out_t out_data_o
);

  // The controller decides what happens in each cycle and tells the datapath through a
  // single operation code; the datapath answers with a handful of status flags that the
  // controller uses to choose its next state.
  dp_op_e   dp_op;
  dp_stat_t dp_stat;

  // The controller also owns both handshakes. An input transfer is taken only while it
  // is idle, but the finished result sits in its own output register, so a new request
  // can be taken and worked on while the previous result is still waiting downstream.
  nfa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .stat_i     (dp_stat),
    .op_o       (dp_op)
  );

  // The datapath holds the used-slot bitmap in a RAM of 64-bit words, the next-fit
  // pointer and the window size. An allocate first checks the pointer slot; failing
  // that, it walks the words of the window starting at the pointer's word and wrapping
  // to word 0, reading one word per cycle, and takes the lowest clear bit of the first
  // word that is not full. When no word has room the window grows by GROW_STEP slots and
  // its first new slot is taken; at full capacity the store-full status comes back.
  nfa_datapath #(
    .CAPACITY (CAPACITY),
    .GROW_STEP(GROW_STEP)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .op_i      (dp_op),
    .in_data_i (in_data_i),
    .stat_o    (dp_stat),
    .out_data_o(out_data_o)
  );

endmodule

FILE: sim/nfa_checker.sv
// Checker for the next-fit code allocator: watches both channels, predicts each result
// from its own copy of the slot bitmap, pointer and window, and compares.
// Depends on nfa_pkg for the payload structs, widths and status codes.
module nfa_checker import nfa_pkg::*; #(
  parameter int unsigned CAPACITY  = CAPACITY_DEF,
  parameter int unsigned GROW_STEP = GROW_STEP_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  nfa_in_t     in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  nfa_out_t    out_data_i,
  output int unsigned failures_o,
  output int unsigned pending_o
);

  localparam int unsigned WORDS = (CAPACITY + WORD_W - 1) / WORD_W;

  logic [WORD_W-1:0] slot_map [WORDS];
  int unsigned       ptr_slot;
  int unsigned       window_slots;
  nfa_out_t          grant_q [$];

  // Every mismatch gets one line in the log and adds one to the count.
  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    failures_o++;
  endtask

  // Lowest clear slot in words [from, upto); returns 1 when one is found.
  function automatic logic find_clear(input int unsigned from, input int unsigned upto,
                                      output int unsigned slot);
    slot = 0;
    for (int unsigned w = from; w < upto && w < WORDS; w++) begin
      if (slot_map[w] != '1) begin
        for (int unsigned b = 0; b < WORD_W; b++) begin
          if (!slot_map[w][b]) begin
            slot = w * WORD_W + b;
            return 1'b1;
          end
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic nfa_out_t predict_grant(input nfa_in_t req);
    nfa_out_t    res;
    int unsigned code;
    int unsigned slot;
    int unsigned first_word;
    logic        found;
    res.granted_code = '0;
    res.status       = STAT_IGNORED;
    code             = req.release_code;
    slot             = 0;
    found            = 1'b0;
    if (req.mode == MODE_RELEASE) begin
      if (code >= CODE_BASE && code - CODE_BASE < CAPACITY) begin
        slot = code - CODE_BASE;
        slot_map[slot / WORD_W][slot % WORD_W] = 1'b0;
        res.status = STAT_RELEASED;
      end
    end else begin
      if (ptr_slot < window_slots && !slot_map[ptr_slot / WORD_W][ptr_slot % WORD_W]) begin
        slot  = ptr_slot;
        found = 1'b1;
      end else begin
        // Scan from the pointer's word to the end of the window, then wrap to word 0.
        first_word = (ptr_slot < window_slots) ? ptr_slot / WORD_W : 0;
        found = find_clear(first_word, window_slots / WORD_W, slot);
        if (!found && first_word != 0) found = find_clear(0, first_word, slot);
      end
      if (!found) begin
        ptr_slot = window_slots;
        if (window_slots + GROW_STEP <= CAPACITY) begin
          slot          = window_slots;
          window_slots += GROW_STEP;
          found         = 1'b1;
        end
      end
      if (found) begin
        slot_map[slot / WORD_W][slot % WORD_W] = 1'b1;
        ptr_slot         = slot + 1;
        res.granted_code = GRANT_W'(CODE_BASE + slot);
        res.status       = STAT_GRANTED;
      end else begin
        res.status = STAT_FULL;
      end
    end
    return res;
  endfunction

  // Results are retired before the transfer of the same edge is predicted: the block
  // works on one request at a time, so a result always belongs to an older request.
  always @(posedge clk_i or negedge rst_ni) begin : track
    nfa_out_t want;
    if (!rst_ni) begin
      for (int unsigned w = 0; w < WORDS; w++) slot_map[w] = '0;
      ptr_slot     = 0;
      window_slots = 0;
      grant_q.delete();
      failures_o   = 0;
      pending_o    = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (grant_q.size() == 0) begin
          report_mismatch("result with nothing outstanding, status", out_data_i.status, 0);
        end else begin
          want = grant_q.pop_front();
          if (out_data_i.granted_code !== want.granted_code)
            report_mismatch("granted_code", out_data_i.granted_code, want.granted_code);
          if (out_data_i.status !== want.status)
            report_mismatch("status", out_data_i.status, want.status);
        end
      end
      if (in_valid_i && in_ready_i) grant_q.push_back(predict_grant(in_data_i));
      pending_o = grant_q.size();
    end
  end

endmodule

FILE: sim/testbench.sv
// Top level of the allocator testbench: clock, reset, request stimulus, result
// back-pressure, watchdog and verdict. Depends on nfa_pkg, next_fit_id_allocator and
// nfa_checker.
module testbench;
  import nfa_pkg::*;

  // Longest correct quiet spell is the deliberate hold-off plus one full scan and grow;
  // the limit leaves ample margin above that.
  localparam int unsigned STALL_LIMIT     = 4000;
  localparam int unsigned DRAIN_CYCLES    = 150;
  localparam int unsigned MIX_ITEMS       = 450;
  localparam int unsigned CHURN_ROUNDS    = 30;
  localparam int unsigned CALM_FROM       = 300;
  localparam int unsigned CALM_TO         = 450;
  localparam int unsigned PRESSURE_AT     = 150;
  localparam int unsigned PRESSURE_CYCLES = 400;
  localparam int unsigned IDLE_PERCENT    = 30;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  nfa_in_t     in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  nfa_out_t    out_data;
  int unsigned failures;
  int unsigned pending;
  int unsigned requests_sent = 0;
  int unsigned results_taken = 0;
  int unsigned quiet_cycles  = 0;

  next_fit_id_allocator dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  nfa_checker #(
    .CAPACITY  (CAPACITY_DEF),
    .GROW_STEP (GROW_STEP_DEF)
  ) checker_i (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .failures_o  (failures),
    .pending_o   (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Reset is applied once; the block then sweeps its bitmap clear before it takes the
  // first transfer, which the sender simply waits out through the handshake.
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Offers one request and returns at the edge where it is transferred. Outside the
  // calm stretch the sender idles at random first, so gaps land on every phase of the
  // block's work. Valid is only lowered when a gap actually follows.
  task automatic request(input logic mode, input logic [CODE_W-1:0] code);
    nfa_in_t item;
    item.mode         = mode;
    item.release_code = code;
    if (requests_sent < CALM_FROM || requests_sent >= CALM_TO) begin
      while ($urandom_range(99) < IDLE_PERCENT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    requests_sent++;
  endtask

  // Release codes lean towards the low slots, where the window is busiest, but also
  // cover the whole in-range span and the full 16-bit field.
  function automatic logic [CODE_W-1:0] pick_release_code();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 60) return CODE_W'(CODE_BASE + $urandom_range(0, 511));
    if (roll < 85) return CODE_W'($urandom_range(CODE_BASE, CODE_BASE + CAPACITY_DEF - 1));
    return CODE_W'($urandom);
  endfunction

  initial begin : stimulus
    int unsigned burst;
    wait (rst_n);
    @(posedge clk);

    // Directed opening: the first allocate opens the window from nothing, then releases
    // probe both edges of the valid code range, a repeated release of a clear slot and a
    // release of a slot beyond the window. The allocate after them carries an all-ones
    // code field, which must be ignored.
    request(MODE_ALLOC,   16'h0000);
    request(MODE_ALLOC,   16'h0000);
    request(MODE_RELEASE, CODE_W'(CODE_BASE - 1));
    request(MODE_RELEASE, 16'h0000);
    request(MODE_RELEASE, CODE_W'(CODE_BASE));
    request(MODE_RELEASE, CODE_W'(CODE_BASE));
    request(MODE_RELEASE, CODE_W'(CODE_BASE + CAPACITY_DEF - 1));
    request(MODE_RELEASE, CODE_W'(CODE_BASE + CAPACITY_DEF));
    request(MODE_RELEASE, 16'hFFFF);
    request(MODE_RELEASE, 16'h8000);
    request(MODE_ALLOC,   16'hFFFF);
    request(MODE_RELEASE, CODE_W'(CODE_BASE + 1));
    request(MODE_ALLOC,   16'h5555);
    request(MODE_ALLOC,   16'hAAAA);
    request(MODE_RELEASE, CODE_W'(CODE_BASE + 3));
    request(MODE_ALLOC,   16'h0000);

    // Mixed traffic: mostly allocates, so the window grows past its first steps while
    // releases punch holes that later scans have to find and wrap round to.
    repeat (MIX_ITEMS) begin
      if ($urandom_range(99) < 65) request(MODE_ALLOC, CODE_W'($urandom));
      else request(MODE_RELEASE, pick_release_code());
    end

    // Churn: a few releases then a few allocates, which forces scans starting
    // mid-window and wrapping back to word zero.
    request(MODE_RELEASE, CODE_W'(CODE_BASE + CAPACITY_DEF - 1));
    request(MODE_ALLOC,   16'h0000);
    repeat (CHURN_ROUNDS) begin
      burst = $urandom_range(1, 3);
      repeat (burst)
        request(MODE_RELEASE,
                CODE_W'($urandom_range(CODE_BASE, CODE_BASE + CAPACITY_DEF - 1)));
      burst = $urandom_range(1, 3);
      repeat (burst) request(MODE_ALLOC, CODE_W'($urandom));
    end
    in_valid <= 1'b0;

    // Outstanding results are counted by the checker; it is sampled on the falling edge
    // so the reading never races its update on the rising edge.
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Result side: random back-pressure, one long hold-off early in the mixed traffic so
  // the block fills and stalls its input, and a calm stretch with ready held high.
  initial begin : receiver
    int unsigned hold;
    logic        pressure_done;
    hold          = 0;
    pressure_done = 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) results_taken++;
      if (!pressure_done && results_taken >= PRESSURE_AT) begin
        pressure_done = 1'b1;
        hold          = PRESSURE_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if (results_taken >= CALM_FROM && results_taken < CALM_TO) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  // Watchdog: counts cycles in which neither channel completes a transfer.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

FILE: filelist.f
sv/nfa_pkg.sv
sv/nfa_ram.sv
sv/nfa_datapath.sv
sv/nfa_ctrl.sv
sv/next_fit_id_allocator.sv
sim/nfa_checker.sv
sim/testbench.sv
